// ===== hdl/m64sh_pkg.sv =====
// Shared types, constants and helper functions for the streaming MurmurHash64A core.
// Depends on nothing; every other file in hdl/ imports this package.
package m64sh_pkg;

    localparam int          LENGTH_BITS = 32;
    localparam int          LEN_W       = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
    localparam logic [63:0] MULT        = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] SEED        = 64'h00000000e17a1465;
    localparam int          SHIFT       = 47;
    localparam int          FIFO_DEPTH  = 4;
    localparam int          PTR_W       = $clog2(FIFO_DEPTH);
    localparam int          CNT_W       = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [63:0] word;
        logic        first;
        logic        last;
        logic [31:0] byte_length;
        logic [63:0] prior_hash;
    } m64sh_in_t;

    typedef struct packed {
        logic [63:0] hash;
        logic        count_error;
    } m64sh_out_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_FULL,
        OP_PART
    } m64sh_op_t;

    typedef struct packed {
        logic             init;
        logic [LEN_W-1:0] len;
        logic [63:0]      prior;
        m64sh_op_t        op;
        logic [63:0]      data;
        logic             last;
        logic             err;
    } m64sh_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_PP,
        ST_INIT_SUM,
        ST_K1_PP,
        ST_K1_SUM,
        ST_K2_PP,
        ST_K2_SUM,
        ST_H_PP,
        ST_H_SUM,
        ST_FIN_PP,
        ST_FIN_SUM
    } m64sh_state_t;

    function automatic logic [63:0] byte_mask(input logic [2:0] n);
        return (64'h1 << {n, 3'b000}) - 64'h1;
    endfunction

    function automatic logic [63:0] xor_shift(input logic [63:0] v);
        return v ^ (v >> SHIFT);
    endfunction

endpackage

// ===== hdl/m64sh_front.sv =====
// Front part: accepts input beats, tracks the remaining length and count errors,
// and turns each beat into a command for the back part. Depends on m64sh_pkg.
module m64sh_front
    import m64sh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  m64sh_in_t  in_data,
    input  logic       full,
    output logic       push,
    output m64sh_cmd_t cmd
);

    logic [LEN_W-1:0] bytes_left_reg;
    logic [LEN_W-1:0] bytes_left_next;
    logic             mismatch_reg;
    logic             mismatch_next;
    logic             accept;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] bl;
    logic             mm;
    logic             empty_start;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign len      = in_data.byte_length[LEN_W-1:0];

    always_comb
    begin
        bl          = in_data.first ? len : bytes_left_reg;
        mm          = in_data.first ? 1'b0 : mismatch_reg;
        empty_start = in_data.first && (len == '0);
        cmd.init    = in_data.first;
        cmd.len     = len;
        cmd.prior   = in_data.prior_hash;
        cmd.last    = in_data.last;
        cmd.op      = OP_NONE;
        cmd.data    = in_data.word;
        if (bl[LEN_W-1:3] != '0)
        begin
            cmd.op = OP_FULL;
            bl     = bl - LEN_W'(8);
        end
        else if (bl != '0)
        begin
            cmd.op   = OP_PART;
            cmd.data = in_data.word & byte_mask(bl[2:0]);
            bl       = '0;
        end
        else if (!empty_start)
        begin
            mm = 1'b1;
        end
        cmd.err = mm || (bl != '0);
        if (in_data.last)
        begin
            bl = '0;
            mm = 1'b0;
        end
        push            = accept && (in_data.first || in_data.last || cmd.op != OP_NONE);
        bytes_left_next = accept ? bl : bytes_left_reg;
        mismatch_next   = accept ? mm : mismatch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            mismatch_reg   <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            mismatch_reg   <= mismatch_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last) |=> (bytes_left_reg == '0 && !mismatch_reg))
        else $error("length tracking not cleared after a last beat");
    a_full_word_consumes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !in_data.first && cmd.op == OP_FULL && !in_data.last)
        |=> (bytes_left_reg == $past(bytes_left_reg) - LEN_W'(8)))
        else $error("full word did not consume eight bytes");
`endif

endmodule

// ===== hdl/m64sh_fifo.sv =====
// Short command queue between the front and back parts.
// Depends on m64sh_pkg for the command type and depth.
module m64sh_fifo
    import m64sh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  m64sh_cmd_t push_data,
    input  logic       pop,
    output m64sh_cmd_t head,
    output logic       full,
    output logic       empty
);

    m64sh_cmd_t       mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");
`endif

endmodule

// ===== hdl/m64sh_back.sv =====
// Back part: runs commands through one shared 64-bit multiplier (partial products, then sum)
// and holds the result beat. Depends on m64sh_pkg.
module m64sh_back
    import m64sh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  m64sh_cmd_t head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output m64sh_out_t out_data
);

    m64sh_state_t state_reg;
    m64sh_state_t state_next;
    m64sh_state_t disp_state;
    m64sh_cmd_t   cmd_reg;
    m64sh_cmd_t   cmd_next;
    m64sh_cmd_t   cur;
    logic [63:0]  h_reg;
    logic [63:0]  h_next;
    logic [63:0]  k_reg;
    logic [63:0]  k_next;
    logic [63:0]  prior_reg;
    logic [63:0]  prior_next;
    logic         ov_reg;
    logic         ov_next;
    m64sh_out_t   out_reg;
    m64sh_out_t   out_next;
    logic [63:0]  h_base;
    logic [63:0]  disp_h;
    logic [63:0]  operand;
    logic [63:0]  pp0_reg;
    logic [31:0]  pp1_reg;
    logic [31:0]  pp2_reg;
    logic [63:0]  prod;

    assign out_valid = ov_reg;
    assign out_data  = out_reg;
    assign prod      = pp0_reg + {pp1_reg + pp2_reg, 32'h0};

    always_comb
    begin
        case (state_reg)
            ST_INIT_PP, ST_INIT_SUM: operand = 64'(cmd_reg.len);
            ST_K1_PP, ST_K1_SUM:     operand = cmd_reg.data;
            ST_K2_PP, ST_K2_SUM:     operand = k_reg;
            ST_H_PP, ST_H_SUM:       operand = h_reg;
            ST_FIN_PP, ST_FIN_SUM:   operand = xor_shift(h_reg);
            default:                 operand = h_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        pp0_reg <= 64'(operand[31:0]) * 64'(MULT[31:0]);
        pp1_reg <= operand[63:32] * MULT[31:0];
        pp2_reg <= operand[31:0] * MULT[63:32];
    end

    always_comb
    begin
        cur    = (state_reg == ST_IDLE) ? head : cmd_reg;
        h_base = (state_reg == ST_INIT_SUM) ? (SEED ^ prod) : h_reg;
        case (cur.op)
            OP_FULL:
            begin
                disp_state = ST_K1_PP;
                disp_h     = h_base;
            end
            OP_PART:
            begin
                disp_state = ST_H_PP;
                disp_h     = h_base ^ cur.data;
            end
            default:
            begin
                disp_state = cur.last ? ST_FIN_PP : ST_IDLE;
                disp_h     = h_base;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        prior_next = prior_reg;
        ov_next    = ov_reg && !out_ready;
        out_next   = out_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    if (head.init)
                    begin
                        prior_next = head.prior;
                        state_next = ST_INIT_PP;
                    end
                    else
                    begin
                        state_next = disp_state;
                        h_next     = disp_h;
                    end
                end
            end
            ST_INIT_PP: state_next = ST_INIT_SUM;
            ST_INIT_SUM:
            begin
                state_next = disp_state;
                h_next     = disp_h;
            end
            ST_K1_PP: state_next = ST_K1_SUM;
            ST_K1_SUM:
            begin
                k_next     = xor_shift(prod);
                state_next = ST_K2_PP;
            end
            ST_K2_PP: state_next = ST_K2_SUM;
            ST_K2_SUM:
            begin
                h_next     = h_reg ^ prod;
                state_next = ST_H_PP;
            end
            ST_H_PP: state_next = ST_H_SUM;
            ST_H_SUM:
            begin
                h_next     = prod;
                state_next = cmd_reg.last ? ST_FIN_PP : ST_IDLE;
            end
            ST_FIN_PP: state_next = ST_FIN_SUM;
            ST_FIN_SUM:
            begin
                if (!ov_reg || out_ready)
                begin
                    out_next.hash        = xor_shift(prod) ^ prior_reg;
                    out_next.count_error = cmd_reg.err;
                    ov_next              = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        k_reg   <= k_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            h_reg     <= '0;
            prior_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            prior_reg <= prior_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN_SUM && (!ov_reg || out_ready)) |=> (ov_reg && state_reg == ST_IDLE))
        else $error("finalized hash not loaded into the output register");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE && !empty))
        else $error("command popped while the datapath was busy");
`endif

endmodule

// ===== hdl/murmur64a_stream_hash_core.sv =====
// Streaming MurmurHash64A core: top level joining front part, command queue and back part.
// Depends on m64sh_pkg, m64sh_front, m64sh_fifo and m64sh_back.
//
// Usage: the input channel (in_valid, in_ready, in_data) takes one little-endian 64-bit
// word per beat. The first beat of a string carries the byte length and the prior hash;
// an empty string is one beat marked both first and last. Only a beat marked last yields
// an output beat (out_valid, out_ready, out_data) with the hash and a count error flag.
// The front part takes a beat in the cycle it is offered as long as the four-entry command
// queue has room. The back part owns one 64-bit multiplier built from 32-bit partial
// products and runs one command at a time: a dispatch step, plus a length multiply on a
// first word, three chained multiplies for a full word, one for a partial word and one
// for the finalizer. Words beyond the length that are not first or last never reach
// the back part, since the front part does not push them into the queue.
// Reset clears the length tracking, the running hash, the held prior hash and the queue.
// When the receiver stalls, the result waits in the output register; the back part stalls
// only when a second result is ready, and the queue then holds up to four commands.
module murmur64a_stream_hash_core
    import m64sh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  m64sh_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output m64sh_out_t out_data
);

    m64sh_cmd_t push_cmd;
    m64sh_cmd_t head_cmd;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;

    m64sh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .full     (full),
        .push     (push),
        .cmd      (push_cmd)
    );

    m64sh_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .full      (full),
        .empty     (empty)
    );

    m64sh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== sim/tb_murmur64a_stream_hash_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for murmur64a_stream_hash_core: directed and random word streams.
// A scoreboard class predicts each MurmurHash64A result and checks the output beats.
// Depends on m64sh_pkg and the core's RTL in hdl/.
module tb_murmur64a_stream_hash_core;
    import m64sh_pkg::*;

    localparam int          HOLD_CYCLES  = 300;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          ITEM_TARGET  = 450;
    localparam logic [31:0] LEN_KEEP     = (LENGTH_BITS >= 32) ? 32'hffffffff :
                                           32'((64'h1 << LENGTH_BITS) - 64'h1);

    class hash_scoreboard;
        m64sh_out_t  pending_hashes[$];
        logic [63:0] run_hash;
        logic [31:0] left_bytes;
        logic [63:0] saved_prior;
        logic        count_bad;
        int          mismatches;
        int          results_seen;

        function new();
            run_hash     = '0;
            left_bytes   = '0;
            saved_prior  = '0;
            count_bad    = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void note_word(m64sh_in_t beat);
            logic [63:0] k;
            logic [63:0] h;
            logic [31:0] len;
            logic        empty_start;
            m64sh_out_t  res;
            empty_start = 1'b0;
            len = beat.byte_length & LEN_KEEP;
            if (beat.first)
            begin
                run_hash    = SEED ^ (64'(len) * MULT);
                left_bytes  = len;
                saved_prior = beat.prior_hash;
                count_bad   = 1'b0;
                empty_start = (len == 0);
            end
            if (left_bytes >= 8)
            begin
                k = beat.word * MULT;
                k = k ^ (k >> SHIFT);
                k = k * MULT;
                run_hash   = (run_hash ^ k) * MULT;
                left_bytes = left_bytes - 8;
            end
            else if (left_bytes != 0)
            begin
                run_hash   = (run_hash ^ (beat.word & ((64'h1 << (8 * left_bytes)) - 64'h1)))
                             * MULT;
                left_bytes = '0;
            end
            else if (!empty_start)
            begin
                count_bad = 1'b1;
            end
            if (beat.last)
            begin
                if (left_bytes != 0)
                    count_bad = 1'b1;
                h = run_hash;
                h = h ^ (h >> SHIFT);
                h = h * MULT;
                h = h ^ (h >> SHIFT);
                res.hash        = h ^ saved_prior;
                res.count_error = count_bad;
                pending_hashes.push_back(res);
                left_bytes = '0;
                count_bad  = 1'b0;
            end
        endfunction

        function void check_result(m64sh_out_t got);
            m64sh_out_t want;
            results_seen++;
            if (pending_hashes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d arrived with none outstanding: hash %h err %0b",
                             results_seen, got.hash, got.count_error);
                return;
            end
            want = pending_hashes.pop_front();
            if (got.hash !== want.hash || got.count_error !== want.count_error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: hash exp %h got %h, count_error exp %0b got %0b",
                             results_seen, want.hash, got.hash, want.count_error,
                             got.count_error);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    m64sh_in_t  in_data;
    logic       out_valid;
    logic       out_ready;
    m64sh_out_t out_data;

    hash_scoreboard sb = new();
    bit             hold_req;
    int             burst_left;
    int             items_sent;

    murmur64a_stream_hash_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic m64sh_in_t pack_beat(logic [63:0] word, logic first, logic last,
                                            logic [31:0] len, logic [63:0] prior);
        m64sh_in_t b;
        b.word        = word;
        b.first       = first;
        b.last        = last;
        b.byte_length = len;
        b.prior_hash  = prior;
        return b;
    endfunction

    task automatic send_word(m64sh_in_t beat);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(beat);
        burst_left--;
    endtask

    task automatic send_string(logic [31:0] len, int n_words, bit with_first, bit with_last);
        for (int i = 0; i < n_words; i++)
        begin
            send_word(pack_beat({$urandom, $urandom}, with_first && i == 0,
                                with_last && i == n_words - 1,
                                (with_first && i == 0) ? len : $urandom,
                                {$urandom, $urandom}));
        end
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (sb.pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    initial
    begin : receiver
        int mode;
        int span;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 64);
            repeat (span)
            begin
                if (hold_req)
                begin
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] len;
        int          n_words;
        int          pick;
        bit          hold_done;
        bit          pause_done;
        hold_req   = 1'b0;
        burst_left = 0;
        items_sent = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(pack_beat({$urandom, $urandom}, 1'b0, 1'b1, 32'd0, '0));
        send_word(pack_beat({$urandom, $urandom}, 1'b0, 1'b0, 32'd5, '1));
        send_word(pack_beat('1, 1'b1, 1'b1, 32'd0, '1));
        send_word(pack_beat('1, 1'b1, 1'b1, 32'd1, '0));
        send_word(pack_beat('1, 1'b1, 1'b1, 32'd7, {$urandom, $urandom}));
        send_word(pack_beat('1, 1'b1, 1'b1, 32'd8, '1));
        send_word(pack_beat('0, 1'b1, 1'b1, 32'd8, '0));
        for (int n = 2; n <= 6; n++)
            send_word(pack_beat({$urandom, $urandom}, 1'b1, 1'b1, n, {$urandom, $urandom}));
        send_string(32'd13, 2, 1'b1, 1'b1);
        send_word(pack_beat({$urandom, $urandom}, 1'b1, 1'b1, 32'hffffffff, '1));
        send_word(pack_beat({$urandom, $urandom}, 1'b1, 1'b1, 32'd16, '0));
        send_string(32'd8, 3, 1'b1, 1'b1);
        send_string(32'd24, 1, 1'b1, 1'b0);
        send_word(pack_beat({$urandom, $urandom}, 1'b1, 1'b1, 32'd4, {$urandom, $urandom}));
        items_sent = 21;

        while (items_sent < ITEM_TARGET)
        begin
            if (!hold_done && items_sent >= 150)
            begin
                hold_req   = 1'b1;
                burst_left = 64;
                repeat (24) send_string($urandom_range(1, 8), 1, 1'b1, 1'b1);
                items_sent += 24;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= 300)
            begin
                wait_for_drain();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                len = (pick < 60) ? $urandom_range(0, 40) : $urandom_range(41, 200);
                n_words = (len == 0) ? 1 : (len + 7) / 8;
                send_string(len, n_words, 1'b1, 1'b1);
                items_sent += n_words;
            end
            else if (pick < 80)
            begin
                n_words = $urandom_range(1, 4);
                send_string($urandom, n_words, 1'b1, 1'b1);
                items_sent += n_words;
            end
            else if (pick < 88)
            begin
                len = $urandom_range(1, 24);
                n_words = (len + 7) / 8 + $urandom_range(1, 2);
                send_string(len, n_words, 1'b1, 1'b1);
                items_sent += n_words;
            end
            else if (pick < 94)
            begin
                n_words = $urandom_range(1, 3);
                send_string($urandom, n_words, 1'b0, 1'b1);
                items_sent += n_words;
            end
            else
            begin
                n_words = $urandom_range(1, 2);
                send_string($urandom_range(9, 40), n_words, 1'b1, 1'b0);
                items_sent += n_words;
            end
        end

        in_valid <= 1'b0;
        while (sb.pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_hashes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/m64sh_pkg.sv
hdl/m64sh_front.sv
hdl/m64sh_fifo.sv
hdl/m64sh_back.sv
hdl/murmur64a_stream_hash_core.sv
sim/tb_murmur64a_stream_hash_core.sv
